// ----- src/ufsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ufsc_pkg
// Shared types, constants and byte classification for the UTF-8 filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ufsc_pkg;

  // longest sequence a lead byte can announce
  localparam int MAX_SEQ_LEN = 6;
  localparam int LEN_W       = $clog2(MAX_SEQ_LEN + 1);

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // replacement character
  localparam logic [7:0] QMARK   = 8'h3F;

  // continuation byte range
  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hBF;

  // lead length codes with special meaning
  localparam logic [LEN_W-1:0] LEN_BAD   = LEN_W'(0);
  localparam logic [LEN_W-1:0] LEN_ASCII = LEN_W'(1);

  // classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] len;
    logic             cont;
  } entry_t;

  // sequence length announced by a lead byte, LEN_BAD for a bad lead
  function automatic logic [LEN_W-1:0] seq_len(input logic [7:0] b);
    logic [LEN_W-1:0] l;
    l = LEN_BAD;
    if (b[7] == 1'b0)             l = LEN_ASCII;
    else if (b[7:5] == 3'h6)      l = LEN_W'(2);
    else if (b[7:4] == 4'hE)      l = LEN_W'(3);
    else if (b[7:3] == 5'h1E)     l = LEN_W'(4);
    else if (b[7:2] == 6'h3E)     l = LEN_W'(5);
    else if (b[7:1] == 7'h7E)     l = LEN_W'(6);
    return l;
  endfunction

  // continuation byte test
  function automatic logic is_cont(input logic [7:0] b);
    return (b >= CONT_LO) && (b <= CONT_HI);
  endfunction

endpackage

`default_nettype wire

// ----- src/utf8_supplementary_char_filter_core.sv -----
// ----------------------------------------------------------------------------
// utf8_supplementary_char_filter_core
// Byte-stream UTF-8 filter: passes ASCII and 2/3-byte sequences, turns
// 4- to 6-byte sequences and broken input into '?'.
// ----------------------------------------------------------------------------
// path: input transfer, queue entry, result plan, then the output register drives out_valid
// throughput: one result per cycle from the back parser while out_ready allows; a byte
//   that yields n results holds the back until all n are emitted, the queue absorbs bursts
// reset: rst_n synchronous, clears queue, parser state and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_supplementary_char_filter_core #(
  parameter int QUEUE_DEPTH = ufsc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_item_last,
  output logic            out_string_done
);

  ufsc_pkg::entry_t push_entry;
  ufsc_pkg::entry_t pop_entry;
  logic             push, full, pop, not_empty;

  // classifying front
  ufsc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .q_full       (full),
    .q_push       (push),
    .q_entry      (push_entry)
  );

  // queue between front and back
  ufsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .pop_entry  (pop_entry)
  );

  // parser and result sequencer
  ufsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (not_empty),
    .q_entry         (pop_entry),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_item_last   (out_item_last),
    .out_string_done (out_string_done)
  );

endmodule

`default_nettype wire

// ----- src/ufsc_front.sv -----
// ----------------------------------------------------------------------------
// ufsc_front
// Input side: takes byte transfers and classifies each byte for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ufsc_front (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last_byte,
  input  wire logic           q_full,
  output logic                q_push,
  output ufsc_pkg::entry_t    q_entry
);

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // lead class and continuation flag travel with the byte
  always_comb begin
    q_entry.data = in_byte;
    q_entry.last = in_last_byte;
    q_entry.len  = ufsc_pkg::seq_len(in_byte);
    q_entry.cont = ufsc_pkg::is_cont(in_byte);
  end

endmodule

`default_nettype wire

// ----- src/ufsc_fifo.sv -----
// ----------------------------------------------------------------------------
// ufsc_fifo
// Small register queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
`default_nettype none

module ufsc_fifo #(
  parameter int DEPTH = ufsc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ufsc_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output ufsc_pkg::entry_t      pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ufsc_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- src/ufsc_back.sv -----
// ----------------------------------------------------------------------------
// ufsc_back
// Parser and result sequencer: pops classified bytes, tracks the open
// sequence and emits the results of each byte one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ufsc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_not_empty,
  input  wire ufsc_pkg::entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_byte_valid,
  output logic                  out_item_last,
  output logic                  out_string_done
);

  localparam int LW = ufsc_pkg::LEN_W;

  // parser state
  logic [LW-1:0] pc_r, pc_nxt;
  logic          skip_r, skip_nxt;
  logic [7:0]    lead_r, lead_nxt;
  logic [7:0]    cont1_r, cont1_nxt;
  logic [LW-1:0] len_r, len_nxt;

  // result plan of the current byte
  logic          busy_r, busy_nxt;
  logic [2:0]    pre_r, pre_nxt;
  logic [2:0]    post_r, post_nxt;
  logic [1:0]    dcnt_r, dcnt_nxt;
  logic [7:0]    d0_r, d0_nxt;
  logic [7:0]    d1_r, d1_nxt;
  logic [7:0]    d2_r, d2_nxt;
  logic          last_r, last_nxt;

  // output register
  logic          ovalid_r, ovalid_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          obval_r, obval_nxt;
  logic          olast_r, olast_nxt;
  logic          odone_r, odone_nxt;

  // plan built from the popped byte
  logic [2:0]    p_pre, p_post;
  logic [1:0]    p_dcnt;
  logic [7:0]    p_d0, p_d1, p_d2;
  logic [LW-1:0] p_pc, p_len, pc_inc;
  logic          p_skip, p_fresh;
  logic [7:0]    p_lead, p_cont1;

  logic [3:0]    remain;
  logic          out_free, emit, final_res, plan_free;

  assign out_free  = !ovalid_r || out_ready;
  assign emit      = busy_r && out_free;
  assign remain    = {1'b0, pre_r} + {2'b0, dcnt_r} + {1'b0, post_r};
  assign final_res = (remain <= 4'd1);
  assign plan_free = !busy_r || (emit && final_res);
  assign q_pop     = plan_free && q_not_empty;

  // parse one byte: state update and its list of results
  always_comb begin
    p_pre   = '0;
    p_post  = '0;
    p_dcnt  = '0;
    p_d0    = q_entry.data;
    p_d1    = '0;
    p_d2    = '0;
    p_pc    = pc_r;
    p_skip  = skip_r;
    p_lead  = lead_r;
    p_cont1 = cont1_r;
    p_len   = len_r;
    p_fresh = 1'b0;
    pc_inc  = pc_r + 1'b1;

    if (skip_r) begin
      // byte after a bad lead is dropped
      p_skip = 1'b0;
    end else if (pc_r == '0) begin
      p_fresh = 1'b1;
    end else if (q_entry.cont) begin
      if (pc_inc >= len_r) begin
        // sequence complete
        p_pc = '0;
        if (len_r == LW'(2)) begin
          p_d0   = lead_r;
          p_d1   = q_entry.data;
          p_dcnt = 2'd2;
        end else if (len_r == LW'(3)) begin
          p_d0   = lead_r;
          p_d1   = cont1_r;
          p_d2   = q_entry.data;
          p_dcnt = 2'd3;
        end else begin
          p_pre = 3'd1;
        end
      end else begin
        if (pc_r == LW'(1)) begin
          p_cont1 = q_entry.data;
        end
        p_pc = pc_inc;
      end
    end else begin
      // broken sequence: buffered continuations reparse as bad leads,
      // two bytes each, and the new byte survives only on an even count
      p_pc  = '0;
      p_pre = 3'd1;
      if (pc_r >= LW'(2)) begin
        p_pre   = 3'd1 + 3'((pc_r - 1'b1) >> 1);
        p_fresh = !pc_r[0];
      end
    end

    // new lead parse
    if (p_fresh) begin
      if (q_entry.len == ufsc_pkg::LEN_ASCII) begin
        p_d0   = q_entry.data;
        p_dcnt = 2'd1;
      end else if (q_entry.len == ufsc_pkg::LEN_BAD) begin
        p_pre  = p_pre + 3'd1;
        p_skip = 1'b1;
      end else begin
        p_lead = q_entry.data;
        p_len  = q_entry.len;
        p_pc   = LW'(1);
      end
    end

    // end of string closes an open sequence
    if (q_entry.last) begin
      if (p_pc != '0) begin
        p_post = 3'd1;
        if (p_pc >= LW'(2)) begin
          p_post = 3'd1 + 3'((p_pc - 1'b1) >> 1);
        end
      end
      p_pc   = '0;
      p_skip = 1'b0;
    end
  end

  // plan, state and output register next values
  always_comb begin
    pc_nxt    = pc_r;
    skip_nxt  = skip_r;
    lead_nxt  = lead_r;
    cont1_nxt = cont1_r;
    len_nxt   = len_r;
    busy_nxt  = busy_r;
    pre_nxt   = pre_r;
    post_nxt  = post_r;
    dcnt_nxt  = dcnt_r;
    d0_nxt    = d0_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    last_nxt  = last_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    obval_nxt  = obval_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;

    // emit one result of the current plan
    if (emit) begin
      ovalid_nxt = 1'b1;
      obval_nxt  = 1'b1;
      olast_nxt  = final_res;
      odone_nxt  = final_res && last_r;
      if (pre_r != '0) begin
        obyte_nxt = ufsc_pkg::QMARK;
        pre_nxt   = pre_r - 1'b1;
      end else if (dcnt_r != '0) begin
        obyte_nxt = d0_r;
        d0_nxt    = d1_r;
        d1_nxt    = d2_r;
        dcnt_nxt  = dcnt_r - 1'b1;
      end else if (post_r != '0) begin
        obyte_nxt = ufsc_pkg::QMARK;
        post_nxt  = post_r - 1'b1;
      end else begin
        obyte_nxt = '0;
        obval_nxt = 1'b0;
      end
      if (final_res) begin
        busy_nxt = 1'b0;
      end
    end

    // load the next byte
    if (q_pop) begin
      pc_nxt    = p_pc;
      skip_nxt  = p_skip;
      lead_nxt  = p_lead;
      cont1_nxt = p_cont1;
      len_nxt   = p_len;
      pre_nxt   = p_pre;
      post_nxt  = p_post;
      dcnt_nxt  = p_dcnt;
      d0_nxt    = p_d0;
      d1_nxt    = p_d1;
      d2_nxt    = p_d2;
      last_nxt  = q_entry.last;
      busy_nxt  = (p_pre != '0) || (p_post != '0) || (p_dcnt != '0) || q_entry.last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      skip_r   <= 1'b0;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      skip_r   <= skip_nxt;
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lead_r  <= lead_nxt;
    cont1_r <= cont1_nxt;
    len_r   <= len_nxt;
    pre_r   <= pre_nxt;
    post_r  <= post_nxt;
    dcnt_r  <= dcnt_nxt;
    d0_r    <= d0_nxt;
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    last_r  <= last_nxt;
    obyte_r <= obyte_nxt;
    obval_r <= obval_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_byte        = obyte_r;
  assign out_byte_valid  = obval_r;
  assign out_item_last   = olast_r;
  assign out_string_done = odone_r;

endmodule

`default_nettype wire

// ----- tb/tb_utf8_supplementary_char_filter_core.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_supplementary_char_filter_core
// Self-checking bench for the UTF-8 filter core. Strings are fed one byte per
// transfer with random gaps. A scoreboard follows the parser state and queues
// the filtered bytes each input must produce. Every output transfer is
// compared with the oldest queued byte. A directed pass covers the lead
// classes, broken and truncated sequences and the end-of-string flush. The
// random strings that follow are mostly well formed, with noise mixed in.
// ----------------------------------------------------------------------------

typedef struct {
  bit [7:0] data;
  bit       bvalid;
  bit       ilast;
  bit       done;
} filt_result_t;

class utf8_filter_scoreboard;
  localparam int MAX_RESULTS = 8;
  localparam int REPARSE_CAP = 16;

  bit [7:0]     held[ufsc_pkg::MAX_SEQ_LEN];
  int           held_cnt;
  bit           skip_next;
  filt_result_t step_res[$];
  filt_result_t expected_out[$];
  int           errors;

  function new();
    held_cnt  = 0;
    skip_next = 1'b0;
    errors    = 0;
  endfunction

  // sequence length from the run of leading ones, 0 for a bad lead
  function int unsigned lead_length(bit [7:0] b);
    int unsigned ones;
    ones = 0;
    while (ones < 8 && b[7 - ones]) ones++;
    if (ones == 0) return ufsc_pkg::LEN_ASCII;
    if (ones >= 2 && ones <= ufsc_pkg::MAX_SEQ_LEN) return ones;
    return ufsc_pkg::LEN_BAD;
  endfunction

  function void emit(bit [7:0] d, bit v);
    filt_result_t r;
    r.data   = v ? d : 8'h00;
    r.bvalid = v;
    r.ilast  = 1'b0;
    r.done   = 1'b0;
    if (step_res.size() < MAX_RESULTS) step_res.push_back(r);
  endfunction

  // walk a byte list through the parser, re-inserting bytes of a broken run
  function void parse_bytes(bit [7:0] q[$]);
    int          qi;
    int          n2;
    int          k;
    bit [7:0]    b;
    int unsigned len;
    qi = 0;
    while (qi < q.size() && qi < REPARSE_CAP) begin
      b = q[qi];
      qi++;
      if (skip_next) begin
        skip_next = 1'b0;
        continue;
      end
      // idle: classify a new lead
      if (held_cnt == 0) begin
        len = lead_length(b);
        if (len == ufsc_pkg::LEN_ASCII) begin
          emit(b, 1'b1);
        end else if (len == ufsc_pkg::LEN_BAD) begin
          emit(ufsc_pkg::QMARK, 1'b1);
          skip_next = 1'b1;
        end else begin
          held[0]  = b;
          held_cnt = 1;
        end
        continue;
      end
      // open sequence takes a continuation byte
      if (b >= ufsc_pkg::CONT_LO && b <= ufsc_pkg::CONT_HI) begin
        len = lead_length(held[0]);
        if (held_cnt < ufsc_pkg::MAX_SEQ_LEN) begin
          held[held_cnt] = b;
          held_cnt++;
        end
        if (held_cnt >= len) begin
          if (len <= 3) begin
            for (k = 0; k < len && k < ufsc_pkg::MAX_SEQ_LEN; k++) emit(held[k], 1'b1);
          end else begin
            emit(ufsc_pkg::QMARK, 1'b1);
          end
          held_cnt = 0;
        end
        continue;
      end
      // broken sequence: lead and next byte consumed, the rest parsed again
      emit(ufsc_pkg::QMARK, 1'b1);
      if (held_cnt >= 2) begin
        n2 = held_cnt - 2;
        if (q.size() + n2 <= REPARSE_CAP) begin
          for (k = n2 - 1; k >= 0; k--) q.insert(qi - 1, held[k + 2]);
          qi = qi - 1;
        end
      end
      held_cnt = 0;
    end
  endfunction

  // predict the results of one accepted input byte
  function void accept_byte(bit [7:0] b, bit last);
    bit [7:0] q[$];
    int       n2;
    int       k;
    step_res.delete();
    q.push_back(b);
    parse_bytes(q);
    if (last) begin
      // flush whatever is still open at the end of the string
      while (held_cnt > 0) begin
        n2 = held_cnt - 2;
        emit(ufsc_pkg::QMARK, 1'b1);
        q.delete();
        for (k = 0; k < n2; k++) q.push_back(held[k + 2]);
        held_cnt = 0;
        parse_bytes(q);
      end
      skip_next = 1'b0;
      if (step_res.size() == 0) emit(8'h00, 1'b0);
    end
    foreach (step_res[i]) begin
      step_res[i].ilast = (i == step_res.size() - 1);
      step_res[i].done  = step_res[i].ilast && last;
      expected_out.push_back(step_res[i]);
    end
  endfunction

  function void check_result(bit [7:0] d, bit bv, bit il, bit sd);
    filt_result_t e;
    if (expected_out.size() == 0) begin
      $error("unexpected result: out_byte %h byte_valid %b item_last %b string_done %b",
             d, bv, il, sd);
      errors++;
      return;
    end
    e = expected_out.pop_front();
    if (d != e.data) begin
      $error("out_byte: expected %h, got %h", e.data, d);
      errors++;
    end
    if (bv != e.bvalid) begin
      $error("out_byte_valid: expected %b, got %b", e.bvalid, bv);
      errors++;
    end
    if (il != e.ilast) begin
      $error("out_item_last: expected %b, got %b", e.ilast, il);
      errors++;
    end
    if (sd != e.done) begin
      $error("out_string_done: expected %b, got %b", e.done, sd);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_out.size();
  endfunction
endclass

module tb_utf8_supplementary_char_filter_core;

  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 150;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_item_last;
  logic       out_string_done;

  utf8_filter_scoreboard sb;
  int items_sent;
  bit idle_off;
  bit hold_req;
  bit hold_done;

  utf8_supplementary_char_filter_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_item_last   (out_item_last),
    .out_string_done (out_string_done)
  );

  // clock, period 2
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.accept_byte(in_byte, in_last_byte);
      if (out_valid && out_ready)
        sb.check_result(out_byte, out_byte_valid, out_item_last, out_string_done);
    end
  end

  // one input transfer after a random gap
  task automatic send_item(bit [7:0] b, bit last);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // lead of length class n followed by n_cont continuation bytes
  function automatic void add_seq(ref bit [7:0] s[$], input int n, input int n_cont);
    bit [7:0] lead;
    case (n)
      1:       lead = 8'($urandom_range(1, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      4:       lead = 8'hF0 | 8'($urandom_range(0, 7));
      5:       lead = 8'hF8 | 8'($urandom_range(0, 3));
      default: lead = 8'hFC | 8'($urandom_range(0, 1));
    endcase
    s.push_back(lead);
    for (int i = 0; i < n_cont; i++) s.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endfunction

  // random string: mostly valid sequences, some truncated runs and noise
  task automatic send_random_string();
    bit [7:0] s[$];
    int       n_chars;
    int       kind;
    int       slen;
    n_chars = $urandom_range(1, 8);
    for (int c = 0; c < n_chars; c++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        slen = $urandom_range(1, 6);
        add_seq(s, slen, slen - 1);
      end else if (kind == 7) begin
        slen = $urandom_range(2, 6);
        add_seq(s, slen, $urandom_range(0, slen - 2));
      end else if (kind == 8) begin
        s.push_back(8'($urandom_range(1, 255)));
      end else begin
        s.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 191))
                                         : 8'($urandom_range(254, 255)));
      end
    end
    foreach (s[i]) send_item(s[i], i == s.size() - 1);
  endtask

  // result side: random ready gaps and one long hold-off
  initial begin : result_sink
    int wait_cycles;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      wait_cycles = idle_off ? 0 : $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // run limit
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb           = new();
    items_sent   = 0;
    idle_off     = 1'b0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h20;
    in_last_byte = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ascii extremes
    send_item(8'h01, 1'b0);
    send_item(8'h7F, 1'b0);
    // 2- and 3-byte sequences pass
    send_item(8'hC2, 1'b0);
    send_item(8'hA9, 1'b0);
    send_item(8'hE2, 1'b0);
    send_item(8'h82, 1'b0);
    send_item(8'hAC, 1'b0);
    // 6-byte sequence with top continuation bytes collapses to '?'
    send_item(8'hFC, 1'b0);
    repeat (5) send_item(8'hBF, 1'b0);
    // stray continuation as lead, next byte dropped
    send_item(8'h80, 1'b0);
    send_item(8'hFE, 1'b0);
    // broken 4-byte run, the new ascii byte parsed again
    send_item(8'hF0, 1'b0);
    send_item(8'h9F, 1'b0);
    send_item(8'h41, 1'b0);
    // broken 5-byte run with a buffered byte parsed again, then end
    send_item(8'hF8, 1'b0);
    send_item(8'h88, 1'b0);
    send_item(8'h88, 1'b0);
    send_item(8'hC3, 1'b1);
    // bad lead swallows the last byte: done-only result
    send_item(8'hFF, 1'b0);
    send_item(8'h41, 1'b1);
    // end of string with a sequence still open
    send_item(8'hE2, 1'b1);

    // random strings, with stretches of no idling
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_off = ($urandom_range(0, 3) == 0);
      if (items_sent >= RANDOM_ITEMS / 2 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      send_random_string();
    end
    in_valid <= 1'b0;
    idle_off = 1'b0;

    // drain
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ufsc_pkg.sv
src/ufsc_front.sv
src/ufsc_fifo.sv
src/ufsc_back.sv
src/utf8_supplementary_char_filter_core.sv
tb/tb_utf8_supplementary_char_filter_core.sv
